// ===== rtl/glos_pkg.sv =====
// shared types and constants for the grid line-of-sight block
package glos_pkg;

  localparam int COORD_W     = 6;
  localparam int LEVEL_W     = 2;
  localparam int ERR_W       = 9;
  localparam int CMDQ_DEPTH  = 2;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int LEVEL_COUNT_DEF = 4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [COORD_W-1:0] to_x;
    logic [COORD_W-1:0] to_y;
    logic               opaque_bit;
  } in_t;

  typedef struct packed {
    logic answered_kind;
    logic visible;
  } out_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               is_query;
    logic               wr_ok;
    logic               lvl_ok;
    logic               opaque;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               sx_neg;
    logic               sy_neg;
  } cmd_t;

  // queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } cmdq_ctl_t;

  // back end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic cmd_pop;
  } back_stat_t;

endpackage

// ===== rtl/glos_front.sv =====
// front end: classifies an incoming item into a walk or write command
module glos_front #(
  parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF,
  parameter int LEVEL_COUNT = glos_pkg::LEVEL_COUNT_DEF
) (
  input  glos_pkg::in_t  item_i,
  output glos_pkg::cmd_t cmd_o
);

  logic lvl_ok;
  logic x_ok;
  logic y_ok;

  assign lvl_ok = 32'(item_i.level) < LEVEL_COUNT;
  assign x_ok   = 32'(item_i.from_x) < GRID_WIDTH;
  assign y_ok   = 32'(item_i.from_y) < GRID_HEIGHT;

  always_comb begin
    cmd_o.is_query = (item_i.kind == glos_pkg::KIND_QUERY);
    cmd_o.wr_ok    = (item_i.kind == glos_pkg::KIND_WRITE) && lvl_ok && x_ok && y_ok;
    cmd_o.lvl_ok   = lvl_ok;
    cmd_o.opaque   = item_i.opaque_bit;
    cmd_o.level    = item_i.level;
    cmd_o.fx       = item_i.from_x;
    cmd_o.fy       = item_i.from_y;
    cmd_o.tx       = item_i.to_x;
    cmd_o.ty       = item_i.to_y;
    cmd_o.sx_neg   = !(item_i.from_x < item_i.to_x);
    cmd_o.sy_neg   = !(item_i.from_y < item_i.to_y);
    cmd_o.dx       = (item_i.to_x > item_i.from_x) ? item_i.to_x - item_i.from_x
                                                   : item_i.from_x - item_i.to_x;
    cmd_o.dy       = (item_i.to_y > item_i.from_y) ? item_i.to_y - item_i.from_y
                                                   : item_i.from_y - item_i.to_y;
  end

endmodule

// ===== rtl/glos_cmdq.sv =====
// short command queue between front and back end
module glos_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  glos_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output glos_pkg::cmd_t rdata_o,
  output logic           valid_o
);

  localparam int PW = (glos_pkg::CMDQ_DEPTH > 1) ? $clog2(glos_pkg::CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(glos_pkg::CMDQ_DEPTH + 1);

  glos_pkg::cmd_t slot_q [glos_pkg::CMDQ_DEPTH];
  logic [PW-1:0]  wptr_q, wptr_d;
  logic [PW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == CW'(glos_pkg::CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (32'(wptr_q) == glos_pkg::CMDQ_DEPTH - 1) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (32'(rptr_q) == glos_pkg::CMDQ_DEPTH - 1) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/glos_back.sv =====
// back end: opacity memory, clearing sweep, line walker and result register
module glos_back #(
  parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF,
  parameter int LEVEL_COUNT = glos_pkg::LEVEL_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  glos_pkg::cmd_t       cmd_i,
  input  logic                 cmd_valid_i,
  output glos_pkg::back_stat_t stat_o,
  output glos_pkg::out_t       result_o,
  output logic                 result_valid_o,
  input  logic                 result_pop_i
);

  localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int AW = LW + YW + XW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int CW = glos_pkg::COORD_W;
  localparam int EW = glos_pkg::ERR_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic mem [MEM_DEPTH];

  logic [1:0]           state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [CW-1:0]        cx_q, cx_d, cy_q, cy_d;
  logic [CW-1:0]        tx_q, tx_d, ty_q, ty_d;
  logic [CW-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                 sxn_q, sxn_d, syn_q, syn_d;
  logic                 lvl_ok_q, lvl_ok_d;
  logic [LW-1:0]        lvl_q, lvl_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 pend_q, pend_d;
  logic                 rdata_q;
  logic                 out_valid_q, out_valid_d;
  glos_pkg::out_t       out_q, out_d;

  logic                 can_out;
  logic                 cmd_pop;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic                 wdata;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic                 cell_in;
  logic                 blocked;
  logic                 at_tgt;
  logic signed [EW:0]   e2;
  logic signed [EW:0]   dxs;
  logic signed [EW:0]   dys;
  logic                 step_x;
  logic                 step_y;

  assign can_out = !out_valid_q || result_pop_i;
  assign cell_in = lvl_ok_q && (32'(cx_q) < GRID_WIDTH) && (32'(cy_q) < GRID_HEIGHT);
  assign blocked = pend_q && rdata_q;
  assign at_tgt  = (cx_q == tx_q) && (cy_q == ty_q);
  assign dxs     = signed'({{(EW + 1 - CW){1'b0}}, dx_q});
  assign dys     = signed'({{(EW + 1 - CW){1'b0}}, dy_q});
  assign e2      = {err_q, 1'b0};
  assign step_x  = e2 > -dys;
  assign step_y  = e2 < dxs;
  assign raddr   = {lvl_q, YW'(cy_q), XW'(cx_q)};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sxn_d       = sxn_q;
    syn_d       = syn_q;
    lvl_ok_d    = lvl_ok_q;
    lvl_d       = lvl_q;
    err_d       = err_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !result_pop_i;
    out_d       = out_q;
    cmd_pop     = 1'b0;
    we          = 1'b0;
    waddr       = {LW'(cmd_i.level), YW'(cmd_i.fy), XW'(cmd_i.fx)};
    wdata       = cmd_i.opaque;
    re          = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = 1'b0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && can_out) begin
          cmd_pop = 1'b1;
          if (cmd_i.is_query) begin
            state_d  = ST_WALK;
            cx_d     = cmd_i.fx;
            cy_d     = cmd_i.fy;
            tx_d     = cmd_i.tx;
            ty_d     = cmd_i.ty;
            dx_d     = cmd_i.dx;
            dy_d     = cmd_i.dy;
            sxn_d    = cmd_i.sx_neg;
            syn_d    = cmd_i.sy_neg;
            lvl_ok_d = cmd_i.lvl_ok;
            lvl_d    = LW'(cmd_i.level);
            err_d    = EW'(signed'({1'b0, cmd_i.dx})) - EW'(signed'({1'b0, cmd_i.dy}));
            pend_d   = 1'b0;
          end else begin
            we                  = cmd_i.wr_ok;
            out_valid_d         = 1'b1;
            out_d.answered_kind = glos_pkg::KIND_WRITE;
            out_d.visible       = 1'b0;
          end
        end
      end
      ST_WALK: begin
        // opacity of the previous cell is checked before the target test
        if (blocked || at_tgt) begin
          if (can_out) begin
            state_d             = ST_IDLE;
            pend_d              = 1'b0;
            out_valid_d         = 1'b1;
            out_d.answered_kind = glos_pkg::KIND_QUERY;
            out_d.visible       = !blocked;
          end
        end else begin
          re     = cell_in;
          pend_d = cell_in;
          if (step_x) begin
            cx_d = sxn_q ? cx_q - 1'b1 : cx_q + 1'b1;
          end
          if (step_y) begin
            cy_d = syn_q ? cy_q - 1'b1 : cy_q + 1'b1;
          end
          err_d = EW'(32'(err_q) - (step_x ? 32'(dy_q) : 0) + (step_y ? 32'(dx_q) : 0));
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    tx_q     <= tx_d;
    ty_q     <= ty_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sxn_q    <= sxn_d;
    syn_q    <= syn_d;
    lvl_ok_q <= lvl_ok_d;
    lvl_q    <= lvl_d;
    err_q    <= err_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // clearing in the upper bit, command pop in the lower
  assign stat_o          = {(state_q == ST_CLEAR), cmd_pop};
  assign result_o        = out_q;
  assign result_valid_o  = out_valid_q;

endmodule

// ===== rtl/grid_line_of_sight_top.sv =====
// top level of the grid line-of-sight block
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------
//  item     | in        | push / full        | item_i  (in_t)
//  result   | out       | empty / pop        | result_o (out_t)
//
// a write is handled in the back end's idle state; a query walks the line from its start cell towards its target,
// one opacity read per cell before the target, from the single read port of the map memory
// after reset a sweep clears the map, one cell a cycle, all
// 2**(level bits + row bits + column bits) cells (16384 at defaults); full is high meanwhile
// a two-entry command queue lets the front keep taking items while a walk runs
// a finished result waits in the output register; the walker stalls until it is taken
module grid_line_of_sight_top #(
  parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF,
  parameter int LEVEL_COUNT = glos_pkg::LEVEL_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  glos_pkg::in_t  item_i,
  output logic           empty,
  input  logic           pop,
  output glos_pkg::out_t result_o
);

  glos_pkg::cmd_t       front_cmd;
  glos_pkg::cmd_t       q_cmd;
  glos_pkg::cmdq_ctl_t  q_ctl;
  glos_pkg::back_stat_t back_stat;
  logic                 q_full;
  logic                 q_valid;
  logic                 result_valid;

  glos_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  glos_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .wdata_i (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_ctl.pop),
    .rdata_o (q_cmd),
    .valid_o (q_valid)
  );

  glos_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_cmd),
    .cmd_valid_i    (q_ctl.valid),
    .stat_o         (back_stat),
    .result_o       (result_o),
    .result_valid_o (result_valid),
    .result_pop_i   (pop)
  );

  // valid in the upper bit, pop in the lower
  assign q_ctl     = {q_valid, back_stat.cmd_pop};
  assign full      = q_full || back_stat.clearing;
  assign empty     = !result_valid;

  // no item enters while the map is being cleared
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.clearing |-> full)
    else $error("item accepted during clearing sweep");

  // a write answer never reports visibility
  a_write_not_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.answered_kind == glos_pkg::KIND_WRITE)) |-> !result_o.visible)
    else $error("write answer with visible set");

  // a command is taken only when the result register can hold its answer
  a_pop_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.cmd_pop |-> (empty || pop))
    else $error("command taken with result register occupied");

  // a command is never taken from an empty queue
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.cmd_pop |-> q_ctl.valid)
    else $error("command taken from empty queue");

endmodule
